// ===== src/rrr_pkg.sv =====
// rrr_pkg: widths, types and rounding helpers shared by the refraction pipeline.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rrr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEC_W     = 18;
    localparam int IDX_W     = 19;

    localparam longint ONE      = longint'(1) <<< FRAC_BITS;
    localparam longint VEC_MAX  = (longint'(1) <<< (VEC_W - 1)) - 1;
    localparam longint OUT_LIM  = (ONE < VEC_MAX) ? ONE : VEC_MAX;

    // cosine in [-1.0, +1.0]
    localparam int COS_W   = FRAC_BITS + 2;
    localparam int SIN_W   = FRAC_BITS + 1;
    localparam int NIN2_W  = 2 * IDX_W - FRAC_BITS + 1;
    localparam int PROD_W  = NIN2_W + SIN_W;
    localparam int RAD_W   = 2 * IDX_W;
    localparam int ROOT_W  = IDX_W;
    localparam int NC_W    = IDX_W + COS_W + 2 - FRAC_BITS;
    localparam int ALPHA_W = ((ROOT_W + 1 > NC_W) ? ROOT_W + 1 : NC_W) + 1;
    localparam int PA_W    = IDX_W + 1 + VEC_W;
    localparam int PB_W    = ALPHA_W + VEC_W;
    localparam int NUM_W   = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int DIV_W   = NUM_W + 1;
    // quotient bits kept; anything larger saturates
    localparam int QB      = (FRAC_BITS + 1 < 17) ? FRAC_BITS + 1 : 17;

    localparam int S_DATA_W = ((6 * VEC_W + 2 * IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * VEC_W + 7) / 8) * 8;

    localparam logic [1:0] OP_REFRACT = 2'd0;
    localparam logic [1:0] OP_REFLECT = 2'd1;

    typedef enum logic [1:0] {
        K_PASS,
        K_TIR,
        K_REFL,
        K_REFR
    } kind_t;

    typedef logic [2:0][VEC_W-1:0] vec3_t;
    typedef logic [2:0][DIV_W-1:0] dmag3_t;
    typedef logic [2:0][QB-1:0]    q3_t;

    // item context carried around the square root
    typedef struct packed {
        kind_t              kind;
        vec3_t              res;
        vec3_t              dir;
        vec3_t              nrm;
        logic [IDX_W-1:0]   nin;
        logic [IDX_W-1:0]   nout;
        logic               neg;
        logic [NC_W-1:0]    nincos;
    } sq_side_t;

    // item context carried around the divider
    typedef struct packed {
        kind_t  kind;
        vec3_t  res;
    } dv_side_t;

    // round half away from zero, drop FRAC_BITS fraction bits
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (FRAC_BITS - 1);
        if (!x[63]) begin
            mag = 64'(x) + half;
        end else begin
            mag = 64'(-x) + half;
        end
        mag = mag >> FRAC_BITS;
        return x[63] ? -$signed(mag) : $signed(mag);
    endfunction

    // clamp to the output direction range
    function automatic logic [VEC_W-1:0] sat_vec(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x;
        if (y > OUT_LIM) y = OUT_LIM;
        if (y < -OUT_LIM) y = -OUT_LIM;
        return y[VEC_W-1:0];
    endfunction

endpackage

// ===== src/rrr_front.sv =====
// rrr_front: six-stage front end: dot product, cosine, reflection and radicand.
// Depends on rrr_pkg.
`timescale 1ns / 1ps

module rrr_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [1:0]              op,
    input  rrr_pkg::vec3_t          dir,
    input  rrr_pkg::vec3_t          nrm,
    input  logic [rrr_pkg::IDX_W-1:0] nin,
    input  logic [rrr_pkg::IDX_W-1:0] nout,
    output logic                    out_valid,
    output logic [rrr_pkg::RAD_W-1:0] rad,
    output rrr_pkg::sq_side_t       side
);
    import rrr_pkg::*;

    typedef struct packed {
        logic [1:0]         op;
        vec3_t              dir;
        vec3_t              nrm;
        logic [IDX_W-1:0]   nin;
        logic [IDX_W-1:0]   nout;
    } carry_t;

    carry_t carry_in;
    assign carry_in = '{op: op, dir: dir, nrm: nrm, nin: nin, nout: nout};

    // stage A: products
    logic                           a_v_reg;
    carry_t                         a_c_reg;
    logic signed [2*VEC_W-1:0]      a_pdn_reg [3];
    logic [2*IDX_W-1:0]             a_nin2f_reg;
    logic [2*IDX_W-1:0]             a_nout2_reg;
    // stage B: cosine
    logic                           b_v_reg;
    carry_t                         b_c_reg;
    logic signed [COS_W-1:0]        b_cos_reg;
    logic signed [COS_W-1:0]        b_cos_next;
    logic [NIN2_W-1:0]              b_nin2_reg;
    logic [2*IDX_W-1:0]             b_nout2_reg;
    // stage C: cosine products
    logic                           c_v_reg;
    carry_t                         c_c_reg;
    logic signed [2*COS_W-1:0]      c_cc_reg;
    logic signed [IDX_W+COS_W:0]    c_nc_reg;
    logic signed [COS_W+VEC_W-1:0]  c_rn_reg [3];
    logic [NIN2_W-1:0]              c_nin2_reg;
    logic [2*IDX_W-1:0]             c_nout2_reg;
    logic                           c_neg_reg;
    // stage D: rounding, reflection
    logic                           d_v_reg;
    carry_t                         d_c_reg;
    logic [SIN_W-1:0]               d_sin_reg;
    logic [NC_W-1:0]                d_nincos_reg;
    vec3_t                          d_refl_reg;
    vec3_t                          d_refl_next;
    logic [NIN2_W-1:0]              d_nin2_reg;
    logic [2*IDX_W-1:0]             d_nout2_reg;
    logic                           d_neg_reg;
    // stage E: index times sine squared
    logic                           e_v_reg;
    carry_t                         e_c_reg;
    logic [PROD_W-1:0]              e_prod_reg;
    logic [NC_W-1:0]                e_nincos_reg;
    vec3_t                          e_refl_reg;
    logic [2*IDX_W-1:0]             e_nout2_reg;
    logic                           e_neg_reg;
    // stage F: radicand and kind
    logic                           f_v_reg;
    logic [RAD_W-1:0]               f_rad_reg;
    sq_side_t                       f_side_reg;
    sq_side_t                       f_side_next;
    logic signed [PROD_W+1:0]       f_rad_next;

    logic signed [2*VEC_W+1:0]      dot_c;
    logic signed [63:0]             cos_t;

    always_comb begin
        dot_c = (2*VEC_W+2)'(a_pdn_reg[0]) + (2*VEC_W+2)'(a_pdn_reg[1])
              + (2*VEC_W+2)'(a_pdn_reg[2]);
        cos_t = rnd_shift(64'(dot_c));
        if (cos_t > ONE) begin
            b_cos_next = COS_W'(ONE);
        end else if (cos_t < -ONE) begin
            b_cos_next = COS_W'(-ONE);
        end else begin
            b_cos_next = cos_t[COS_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_refl_next[i] = sat_vec(rnd_shift(
                (64'($signed(c_c_reg.dir[i])) <<< FRAC_BITS) - (64'(c_rn_reg[i]) <<< 1)));
        end
    end

    always_comb begin
        f_rad_next = $signed((PROD_W+2)'(e_nout2_reg)) - $signed((PROD_W+2)'(e_prod_reg));
        f_side_next.dir    = e_c_reg.dir;
        f_side_next.nrm    = e_c_reg.nrm;
        f_side_next.nin    = e_c_reg.nin;
        f_side_next.nout   = e_c_reg.nout;
        f_side_next.neg    = e_neg_reg;
        f_side_next.nincos = e_nincos_reg;
        if (e_c_reg.op == OP_REFLECT) begin
            f_side_next.kind = K_REFL;
        end else if (e_c_reg.op == OP_REFRACT && e_c_reg.nout != '0) begin
            f_side_next.kind = f_rad_next[PROD_W+1] ? K_TIR : K_REFR;
        end else begin
            f_side_next.kind = K_PASS;
        end
        f_side_next.res = (f_side_next.kind == K_REFL) ? e_refl_reg : e_c_reg.dir;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_c_reg     <= carry_in;
            for (int i = 0; i < 3; i++) begin
                a_pdn_reg[i] <= (2*VEC_W)'($signed(dir[i])) * (2*VEC_W)'($signed(nrm[i]));
            end
            a_nin2f_reg <= (2*IDX_W)'(nin) * (2*IDX_W)'(nin);
            a_nout2_reg <= (2*IDX_W)'(nout) * (2*IDX_W)'(nout);

            b_c_reg     <= a_c_reg;
            b_cos_reg   <= b_cos_next;
            b_nin2_reg  <= NIN2_W'(rnd_shift(64'(a_nin2f_reg)));
            b_nout2_reg <= a_nout2_reg;

            c_c_reg     <= b_c_reg;
            c_cc_reg    <= (2*COS_W)'(b_cos_reg) * (2*COS_W)'(b_cos_reg);
            c_nc_reg    <= (IDX_W+COS_W+1)'($signed({1'b0, b_c_reg.nin}))
                         * (IDX_W+COS_W+1)'(b_cos_reg);
            for (int i = 0; i < 3; i++) begin
                c_rn_reg[i] <= (COS_W+VEC_W)'(b_cos_reg)
                             * (COS_W+VEC_W)'($signed(b_c_reg.nrm[i]));
            end
            c_nin2_reg  <= b_nin2_reg;
            c_nout2_reg <= b_nout2_reg;
            c_neg_reg   <= b_cos_reg[COS_W-1];

            d_c_reg      <= c_c_reg;
            d_sin_reg    <= SIN_W'(ONE - rnd_shift(64'(c_cc_reg)));
            d_nincos_reg <= NC_W'(rnd_shift(64'(c_nc_reg)));
            d_refl_reg   <= d_refl_next;
            d_nin2_reg   <= c_nin2_reg;
            d_nout2_reg  <= c_nout2_reg;
            d_neg_reg    <= c_neg_reg;

            e_c_reg      <= d_c_reg;
            e_prod_reg   <= PROD_W'(d_nin2_reg) * PROD_W'(d_sin_reg);
            e_nincos_reg <= d_nincos_reg;
            e_refl_reg   <= d_refl_reg;
            e_nout2_reg  <= d_nout2_reg;
            e_neg_reg    <= d_neg_reg;

            f_rad_reg  <= f_rad_next[RAD_W-1:0];
            f_side_reg <= f_side_next;
        end
    end

    assign out_valid = f_v_reg;
    assign rad       = f_rad_reg;
    assign side      = f_side_reg;

endmodule

// ===== src/rrr_sqrt.sv =====
// rrr_sqrt: pipelined integer square root, one root bit per stage.
// Depends on rrr_pkg.
`timescale 1ns / 1ps

module rrr_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rrr_pkg::RAD_W-1:0] rad,
    input  rrr_pkg::sq_side_t         in_side,
    output logic                      out_valid,
    output logic [rrr_pkg::ROOT_W-1:0] root,
    output rrr_pkg::sq_side_t         out_side
);
    import rrr_pkg::*;

    logic                v_reg    [ROOT_W];
    logic [RAD_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    sq_side_t            side_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic              v_in;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        sq_side_t          side_in;
        logic [RAD_W+1:0]  trial;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // square grows by 2*root*2^B + 4^B when bit B is set
        assign trial = ((RAD_W+2)'(root_in) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_in;
                if ((RAD_W+2)'(rem_in) >= trial) begin
                    rem_reg[s]  <= rem_in - trial[RAD_W-1:0];
                    root_reg[s] <= root_in | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== src/rrr_div.sv =====
// rrr_div: three-lane pipelined restoring divider with overflow detect.
// Depends on rrr_pkg.
`timescale 1ns / 1ps

module rrr_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  rrr_pkg::dmag3_t           mag,
    input  logic [2:0]                sgn,
    input  logic [rrr_pkg::IDX_W-1:0] nout,
    input  rrr_pkg::dv_side_t         in_side,
    output logic                      out_valid,
    output rrr_pkg::q3_t              quo,
    output logic [2:0]                ovf,
    output logic [2:0]                out_sgn,
    output rrr_pkg::dv_side_t         out_side
);
    import rrr_pkg::*;

    // entry stage: overflow check against nout * 2^QB
    logic              z_v_reg;
    dmag3_t            z_rem_reg;
    logic [2:0]        z_ovf_reg;
    logic [2:0]        z_sgn_reg;
    logic [IDX_W-1:0]  z_nout_reg;
    dv_side_t          z_side_reg;

    logic              v_reg    [QB];
    dmag3_t            rem_reg  [QB];
    q3_t               q_reg    [QB];
    logic [2:0]        ovf_reg  [QB];
    logic [2:0]        sgn_reg  [QB];
    logic [IDX_W-1:0]  nout_reg [QB];
    dv_side_t          side_reg [QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_v_reg <= 1'b0;
        end else if (en) begin
            z_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_rem_reg  <= mag;
            z_sgn_reg  <= sgn;
            z_nout_reg <= nout;
            z_side_reg <= in_side;
            for (int i = 0; i < 3; i++) begin
                z_ovf_reg[i] <= mag[i] >= (DIV_W'(nout) << QB);
            end
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        localparam int B = QB - 1 - s;
        logic             v_in;
        dmag3_t           rem_in;
        q3_t              q_in;
        logic [2:0]       ovf_in;
        logic [2:0]       sgn_in;
        logic [IDX_W-1:0] nout_in;
        dv_side_t         side_in;
        logic [DIV_W-1:0] dsh;

        if (s == 0) begin : g_first
            assign v_in    = z_v_reg;
            assign rem_in  = z_rem_reg;
            assign q_in    = '0;
            assign ovf_in  = z_ovf_reg;
            assign sgn_in  = z_sgn_reg;
            assign nout_in = z_nout_reg;
            assign side_in = z_side_reg;
        end else begin : g_next
            assign v_in    = v_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign ovf_in  = ovf_reg[s-1];
            assign sgn_in  = sgn_reg[s-1];
            assign nout_in = nout_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign dsh = DIV_W'(nout_in) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[s]  <= ovf_in;
                sgn_reg[s]  <= sgn_in;
                nout_reg[s] <= nout_in;
                side_reg[s] <= side_in;
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dsh) begin
                        rem_reg[s][i] <= rem_in[i] - dsh;
                        q_reg[s][i]   <= q_in[i] | (QB'(1) << B);
                    end else begin
                        rem_reg[s][i] <= rem_in[i];
                        q_reg[s][i]   <= q_in[i];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign ovf       = ovf_reg[QB-1];
    assign out_sgn   = sgn_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

// ===== src/ray_refract_reflect.sv =====
// ray_refract_reflect: top level of the vector Snell refraction / reflection pipeline.
// Depends on rrr_pkg, rrr_front, rrr_sqrt and rrr_div.
`timescale 1ns / 1ps
//
//  channel | direction | tdata (low bit up)                          | tuser
//  --------+-----------+---------------------------------------------+----------------
//  s_      | in        | dir_x,y,z, norm_x,y,z, index_before, _after | opcode [1:0]
//  m_      | out       | out_x, out_y, out_z                         | tir_flag [0]
//
//  One item enters per cycle while s_tready is high. Items pass the front end,
//  the bit-per-stage square root, stages G to I, the divider and the output register.
//  All stages advance together while the output register is empty or taken;
//  when m_tready holds low with a result waiting, the whole pipe holds and
//  s_tready drops. Nothing is lost or repeated across a stall.
//  aresetn clears the valid bits only; payload registers are not reset.

module ray_refract_reflect (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_before, index_after, zero pad
    input  logic [rrr_pkg::S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [rrr_pkg::M_DATA_W-1:0] m_tdata,
    // tir_flag
    output logic [0:0]                   m_tuser
);
    import rrr_pkg::*;

    logic adv;

    // input unpack
    vec3_t            in_dir;
    vec3_t            in_nrm;
    logic [IDX_W-1:0] in_nin;
    logic [IDX_W-1:0] in_nout;

    // front end -> square root
    logic             fr_v;
    logic [RAD_W-1:0] fr_rad;
    sq_side_t         fr_side;

    // square root -> alpha stages
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    // stage G: alpha
    logic                      g_v_reg;
    sq_side_t                  g_side_reg;
    logic signed [ALPHA_W-1:0] g_alpha_reg;
    logic signed [ROOT_W:0]    g_root_s;
    // stage H: numerator products
    logic                      h_v_reg;
    dv_side_t                  h_side_reg;
    logic [IDX_W-1:0]          h_nout_reg;
    logic signed [PA_W-1:0]    h_pa_reg [3];
    logic signed [PB_W-1:0]    h_pb_reg [3];
    // stage I: numerator sum, magnitude with half-divisor bias
    logic                      i_v_reg;
    dv_side_t                  i_side_reg;
    logic [IDX_W-1:0]          i_nout_reg;
    dmag3_t                    i_mag_reg;
    dmag3_t                    i_mag_next;
    logic [2:0]                i_sgn_reg;
    logic [2:0]                i_sgn_next;
    logic signed [NUM_W-1:0]   num_c [3];

    // divider -> output
    logic        dv_v;
    q3_t         dv_q;
    logic [2:0]  dv_ovf;
    logic [2:0]  dv_sgn;
    dv_side_t    dv_side;

    // output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_DATA_W-1:0] m_tdata_next;
    logic                m_tir_reg;
    logic [VEC_W-1:0]    qs_mag [3];

    // advance everything when the output slot is free or being drained
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_dir[i] = s_tdata[i*VEC_W +: VEC_W];
            in_nrm[i] = s_tdata[(3+i)*VEC_W +: VEC_W];
        end
        in_nin  = s_tdata[6*VEC_W +: IDX_W];
        in_nout = s_tdata[6*VEC_W+IDX_W +: IDX_W];
    end

    rrr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .op        (s_tuser),
        .dir       (in_dir),
        .nrm       (in_nrm),
        .nin       (in_nin),
        .nout      (in_nout),
        .out_valid (fr_v),
        .rad       (fr_rad),
        .side      (fr_side)
    );

    rrr_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (fr_v),
        .rad       (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // root takes the sign of cosI; a zero cosine counts as positive
    assign g_root_s = sq_side.neg ? -$signed({1'b0, sq_root}) : $signed({1'b0, sq_root});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_c[i] = NUM_W'(h_pa_reg[i]) + NUM_W'(h_pb_reg[i]);
            i_sgn_next[i] = num_c[i][NUM_W-1];
            // round half away from zero: bias magnitude by half the divisor
            i_mag_next[i] = (num_c[i][NUM_W-1] ? DIV_W'(-num_c[i]) : DIV_W'(num_c[i]))
                          + DIV_W'(h_nout_reg >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
        end else if (adv) begin
            g_v_reg <= sq_v;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_side_reg  <= sq_side;
            g_alpha_reg <= ALPHA_W'(g_root_s) - ALPHA_W'($signed(sq_side.nincos));

            h_side_reg <= '{kind: g_side_reg.kind, res: g_side_reg.res};
            h_nout_reg <= g_side_reg.nout;
            for (int i = 0; i < 3; i++) begin
                h_pa_reg[i] <= PA_W'($signed({1'b0, g_side_reg.nin}))
                             * PA_W'($signed(g_side_reg.dir[i]));
                h_pb_reg[i] <= PB_W'(g_alpha_reg) * PB_W'($signed(g_side_reg.nrm[i]));
            end

            i_side_reg <= h_side_reg;
            i_nout_reg <= h_nout_reg;
            i_mag_reg  <= i_mag_next;
            i_sgn_reg  <= i_sgn_next;
        end
    end

    rrr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (i_v_reg),
        .mag       (i_mag_reg),
        .sgn       (i_sgn_reg),
        .nout      (i_nout_reg),
        .in_side   (i_side_reg),
        .out_valid (dv_v),
        .quo       (dv_q),
        .ovf       (dv_ovf),
        .out_sgn   (dv_sgn),
        .out_side  (dv_side)
    );

    // saturate quotient, restore sign, or pick the carried direction
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (dv_ovf[i] || longint'(dv_q[i]) > OUT_LIM) begin
                qs_mag[i] = VEC_W'(OUT_LIM);
            end else begin
                qs_mag[i] = VEC_W'(dv_q[i]);
            end
            if (dv_side.kind == K_REFR) begin
                m_tdata_next[i*VEC_W +: VEC_W] = dv_sgn[i] ? -qs_mag[i] : qs_mag[i];
            end else begin
                m_tdata_next[i*VEC_W +: VEC_W] = dv_side.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tir_reg   <= (dv_side.kind == K_TIR);
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tir_reg;

endmodule
